// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the relay output sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/roms_pkg.sv =====
// Shared types and constants of the relay output sequencer.
package roms_pkg;

  // item opcodes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_TRIGGER   = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_SET_LEVEL = 3'd3;
  localparam logic [2:0] OP_PULSE     = 3'd4;

  // channel modes
  localparam logic [1:0] MODE_MOMENTARY = 2'd0;
  localparam logic [1:0] MODE_ALTERNATE = 2'd1;
  localparam logic [1:0] MODE_INTERVAL  = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MODE_A     = 3'd0;
  localparam logic [2:0] REG_MODE_B     = 3'd1;
  localparam logic [2:0] REG_DURATION_A = 3'd2;
  localparam logic [2:0] REG_DURATION_B = 3'd3;
  localparam logic [2:0] REG_COUNT_A    = 3'd4;
  localparam logic [2:0] REG_COUNT_B    = 3'd5;
  localparam logic [2:0] REG_ENABLE_A   = 3'd6;
  localparam logic [2:0] REG_ENABLE_B   = 3'd7;

  localparam int DUR_W = 14;
  localparam int CNT_W = 7;
  localparam int TMR_W = 16;

  localparam logic [DUR_W-1:0] DUR_MIN   = 14'd500;
  localparam logic [DUR_W-1:0] DUR_MAX   = 14'd10000;
  localparam logic [DUR_W-1:0] DUR_RESET = 14'd3000;
  localparam logic [CNT_W-1:0] CNT_MIN   = 7'd1;
  localparam logic [CNT_W-1:0] CNT_MAX   = 7'd100;
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DUR_W-1:0] duration;
    logic [CNT_W-1:0] count;
    logic             enable;
  } chan_cfg_t;

  typedef struct packed {
    logic             tick;     // item is a tick
    logic             hit;      // item is a command addressed to this channel
    logic [2:0]       op;
    logic             level;
    logic [TMR_W-1:0] pulse_ms;
  } chan_cmd_t;

  typedef struct packed {
    logic line;
    logic cycling;
    logic timing;
  } chan_stat_t;

endpackage

// ===== rtl/roms_cfg.sv =====
// Configuration register file with clamping on write and APB-style access.
`include "assert_macros.svh"

module roms_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_idx,
  input  logic [31:0]         wr_data,
  input  logic [2:0]          rd_idx,
  output logic [31:0]         rd_data,
  output roms_pkg::chan_cfg_t cfg_a,
  output roms_pkg::chan_cfg_t cfg_b
);

  roms_pkg::chan_cfg_t cfg_a_r, cfg_a_nxt;
  roms_pkg::chan_cfg_t cfg_b_r, cfg_b_nxt;

  logic [1:0]                 mode_w;
  logic [roms_pkg::DUR_W-1:0] dur_w;
  logic [roms_pkg::CNT_W-1:0] cnt_w;

  // clamp incoming values
  always_comb begin
    mode_w = (wr_data[1:0] == roms_pkg::MODE_INTERVAL ||
              wr_data[1:0] == roms_pkg::MODE_ALTERNATE ||
              wr_data[1:0] == roms_pkg::MODE_MOMENTARY) ?
             wr_data[1:0] : roms_pkg::MODE_MOMENTARY;
    if (wr_data[roms_pkg::DUR_W-1:0] < roms_pkg::DUR_MIN) begin
      dur_w = roms_pkg::DUR_MIN;
    end else if (wr_data[roms_pkg::DUR_W-1:0] > roms_pkg::DUR_MAX) begin
      dur_w = roms_pkg::DUR_MAX;
    end else begin
      dur_w = wr_data[roms_pkg::DUR_W-1:0];
    end
    if (wr_data[roms_pkg::CNT_W-1:0] < roms_pkg::CNT_MIN) begin
      cnt_w = roms_pkg::CNT_MIN;
    end else if (wr_data[roms_pkg::CNT_W-1:0] > roms_pkg::CNT_MAX) begin
      cnt_w = roms_pkg::CNT_MAX;
    end else begin
      cnt_w = wr_data[roms_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    cfg_a_nxt = cfg_a_r;
    cfg_b_nxt = cfg_b_r;
    if (wr_en) begin
      case (wr_idx)
        roms_pkg::REG_MODE_A:     cfg_a_nxt.mode     = mode_w;
        roms_pkg::REG_MODE_B:     cfg_b_nxt.mode     = mode_w;
        roms_pkg::REG_DURATION_A: cfg_a_nxt.duration = dur_w;
        roms_pkg::REG_DURATION_B: cfg_b_nxt.duration = dur_w;
        roms_pkg::REG_COUNT_A:    cfg_a_nxt.count    = cnt_w;
        roms_pkg::REG_COUNT_B:    cfg_b_nxt.count    = cnt_w;
        roms_pkg::REG_ENABLE_A:   cfg_a_nxt.enable   = wr_data[0];
        roms_pkg::REG_ENABLE_B:   cfg_b_nxt.enable   = wr_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_a_r <= '{mode: roms_pkg::MODE_MOMENTARY, duration: roms_pkg::DUR_RESET,
                   count: roms_pkg::CNT_RESET, enable: 1'b0};
      cfg_b_r <= '{mode: roms_pkg::MODE_MOMENTARY, duration: roms_pkg::DUR_RESET,
                   count: roms_pkg::CNT_RESET, enable: 1'b0};
    end else begin
      cfg_a_r <= cfg_a_nxt;
      cfg_b_r <= cfg_b_nxt;
    end
  end

  always_comb begin
    rd_data = '0;
    case (rd_idx)
      roms_pkg::REG_MODE_A:     rd_data[1:0] = cfg_a_r.mode;
      roms_pkg::REG_MODE_B:     rd_data[1:0] = cfg_b_r.mode;
      roms_pkg::REG_DURATION_A: rd_data[roms_pkg::DUR_W-1:0] = cfg_a_r.duration;
      roms_pkg::REG_DURATION_B: rd_data[roms_pkg::DUR_W-1:0] = cfg_b_r.duration;
      roms_pkg::REG_COUNT_A:    rd_data[roms_pkg::CNT_W-1:0] = cfg_a_r.count;
      roms_pkg::REG_COUNT_B:    rd_data[roms_pkg::CNT_W-1:0] = cfg_b_r.count;
      roms_pkg::REG_ENABLE_A:   rd_data[0] = cfg_a_r.enable;
      roms_pkg::REG_ENABLE_B:   rd_data[0] = cfg_b_r.enable;
      default: begin
      end
    endcase
  end

  assign cfg_a = cfg_a_r;
  assign cfg_b = cfg_b_r;

  `ASSERT_ALWAYS(a_dur_range, clk, rst_n,
    cfg_a_r.duration >= roms_pkg::DUR_MIN && cfg_a_r.duration <= roms_pkg::DUR_MAX &&
    cfg_b_r.duration >= roms_pkg::DUR_MIN && cfg_b_r.duration <= roms_pkg::DUR_MAX,
    "duration register outside clamp range")
  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n,
    cfg_a_r.count >= roms_pkg::CNT_MIN && cfg_a_r.count <= roms_pkg::CNT_MAX &&
    cfg_b_r.count >= roms_pkg::CNT_MIN && cfg_b_r.count <= roms_pkg::CNT_MAX,
    "count register outside clamp range")

endmodule

// ===== rtl/roms_chan.sv =====
// One output channel: line level, pulse timer and interval run state.
`include "assert_macros.svh"

module roms_chan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,      // item is consumed this cycle
  input  roms_pkg::chan_cfg_t  cfg,
  input  roms_pkg::chan_cmd_t  cmd,
  output roms_pkg::chan_stat_t stat_nxt   // status after the current item
);

  logic                       line_r, line_nxt;
  logic                       run_r, run_nxt;
  logic                       pend_r, pend_nxt;
  logic [roms_pkg::TMR_W-1:0] plen_r, plen_nxt;
  logic [roms_pkg::TMR_W-1:0] elap_r, elap_nxt;
  logic [roms_pkg::CNT_W-1:0] cyc_r, cyc_nxt;

  logic [roms_pkg::TMR_W-1:0] elap_inc;
  logic [roms_pkg::CNT_W-1:0] cyc_dec;
  logic [roms_pkg::TMR_W-1:0] dur_ext;

  // saturating tick counter
  assign elap_inc = (elap_r == {roms_pkg::TMR_W{1'b1}}) ? elap_r
                                                        : elap_r + roms_pkg::TMR_W'(1);
  assign cyc_dec  = (cyc_r != '0) ? cyc_r - roms_pkg::CNT_W'(1) : cyc_r;
  assign dur_ext  = roms_pkg::TMR_W'(cfg.duration);

  always_comb begin
    line_nxt = line_r;
    run_nxt  = run_r;
    pend_nxt = pend_r;
    plen_nxt = plen_r;
    elap_nxt = elap_r;
    cyc_nxt  = cyc_r;
    if (cmd.tick) begin
      if (cfg.enable && pend_r) begin
        // single pulse owns the timer
        if (elap_inc >= plen_r) begin
          line_nxt = 1'b0;
          pend_nxt = 1'b0;
          elap_nxt = '0;
        end else begin
          elap_nxt = elap_inc;
        end
      end else if (run_r && cfg.mode == roms_pkg::MODE_INTERVAL && !pend_r) begin
        if (elap_inc >= dur_ext) begin
          line_nxt = ~line_r;
          elap_nxt = '0;
          if (line_r) begin
            // falling edge closes one cycle
            cyc_nxt = cyc_dec;
            if (cyc_dec == '0) begin
              run_nxt = 1'b0;
            end
          end
        end else begin
          elap_nxt = elap_inc;
        end
      end
    end else if (cmd.hit && cfg.enable) begin
      case (cmd.op)
        roms_pkg::OP_TRIGGER: begin
          if (cfg.mode == roms_pkg::MODE_ALTERNATE) begin
            line_nxt = ~line_r;
            pend_nxt = 1'b0;
          end else if (cfg.mode == roms_pkg::MODE_INTERVAL) begin
            pend_nxt = 1'b0;
            line_nxt = 1'b1;
            cyc_nxt  = cfg.count;
            elap_nxt = '0;
            run_nxt  = 1'b1;
          end else begin
            line_nxt = 1'b1;
            pend_nxt = 1'b1;
            plen_nxt = dur_ext;
            elap_nxt = '0;
          end
        end
        roms_pkg::OP_STOP: begin
          run_nxt  = 1'b0;
          pend_nxt = 1'b0;
          line_nxt = 1'b0;
        end
        roms_pkg::OP_SET_LEVEL: begin
          run_nxt  = 1'b0;
          pend_nxt = 1'b0;
          line_nxt = cmd.level;
        end
        roms_pkg::OP_PULSE: begin
          run_nxt  = 1'b0;
          line_nxt = 1'b1;
          pend_nxt = 1'b1;
          plen_nxt = cmd.pulse_ms;
          elap_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 1'b0;
      run_r  <= 1'b0;
      pend_r <= 1'b0;
      plen_r <= '0;
      elap_r <= '0;
      cyc_r  <= '0;
    end else if (step) begin
      line_r <= line_nxt;
      run_r  <= run_nxt;
      pend_r <= pend_nxt;
      plen_r <= plen_nxt;
      elap_r <= elap_nxt;
      cyc_r  <= cyc_nxt;
    end
  end

  assign stat_nxt = '{line: line_nxt, cycling: run_nxt, timing: pend_nxt};

  `ASSERT_IMPLIES(a_pend_line, clk, rst_n, pend_r, line_r,
    "pending pulse with line low")
  `ASSERT_IMPLIES(a_run_cycles, clk, rst_n, run_r, cyc_r != '0,
    "interval run active with no cycles left")

endmodule

// ===== rtl/relay_output_mode_sequencer.sv =====
// Top level of the two-channel relay output sequencer.
//
//  port group  dir  handshake        payload
//  in_*        in   tvalid/tready    tuser = op, channel; tdata = level, pulse_ms
//  out_*       out  tvalid/tready    tdata = line, cycling, timing for A and B
//  cfg_*       in   psel/penable     8 registers at byte address 4*index
//
// Each item is held in the input register and resolved into the result
// register when it advances; one item per cycle is sustained while out_tready
// is high, and out_tvalid rises once the result register is loaded.
// The channel update is combinational (one add and compare per channel).
// rst_n is synchronous: it clears both channels and loads register defaults.
// A stalled result holds in the output register while the input register
// takes one more item; in_tready drops only when both are full and
// out_tready is low.
`include "assert_macros.svh"

module relay_output_mode_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [0] level, [16:1] pulse_ms, [23:17] zero
  input  logic [3:0]  in_tuser,    // [2:0] op, [3] channel
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] line_a, [1] line_b, [2] cycling_a,
                                   // [3] cycling_b, [4] timing_a, [5] timing_b,
                                   // [7:6] zero
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // input register
  logic                       in_valid_r, in_valid_nxt;
  logic [2:0]                 op_r;
  logic                       chan_r;
  logic                       level_r;
  logic [roms_pkg::TMR_W-1:0] pms_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [5:0] out_data_r;

  logic advance;
  logic in_fire;

  roms_pkg::chan_cfg_t  cfg_a, cfg_b;
  roms_pkg::chan_cmd_t  cmd_a, cmd_b;
  roms_pkg::chan_stat_t stat_a, stat_b;

  // an item leaves the input register when the result register is empty or being read out
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_tuser[2:0];
      chan_r  <= in_tuser[3];
      level_r <= in_tdata[0];
      pms_r   <= in_tdata[16:1];
    end
    if (advance) begin
      out_data_r <= {stat_b.timing, stat_a.timing, stat_b.cycling, stat_a.cycling,
                     stat_b.line, stat_a.line};
    end
  end

  // register file
  assign cfg_pready = 1'b1;

  roms_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready),
    .wr_idx  (cfg_paddr[4:2]),
    .wr_data (cfg_pwdata),
    .rd_idx  (cfg_paddr[4:2]),
    .rd_data (cfg_prdata),
    .cfg_a   (cfg_a),
    .cfg_b   (cfg_b)
  );

  // per-channel command decode
  assign cmd_a = '{tick: op_r == roms_pkg::OP_TICK, hit: !chan_r, op: op_r,
                   level: level_r, pulse_ms: pms_r};
  assign cmd_b = '{tick: op_r == roms_pkg::OP_TICK, hit: chan_r, op: op_r,
                   level: level_r, pulse_ms: pms_r};

  roms_chan u_chan_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .cfg      (cfg_a),
    .cmd      (cmd_a),
    .stat_nxt (stat_a)
  );

  roms_chan u_chan_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .cfg      (cfg_b),
    .cmd      (cmd_b),
    .stat_nxt (stat_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  `ASSERT_NEXT(a_advance_result, clk, rst_n, advance, out_valid_r,
    "consumed item produced no result")

endmodule
